### hdl/cffcs_pkg.sv
// Shared types and constants for the CFF charset range encoder.
// Used by cff_charset_range_encoder_unit; depends on nothing else.
package cffcs_pkg;

    localparam int ID_W   = 16;
    localparam int CNT_W  = 17;
    localparam int RUN_W  = 8;
    localparam int SIZE_W = 18;
    localparam int FMT_W  = 2;
    localparam int MAX_RESULTS = 6;
    localparam int RCNT_W = 3;

    localparam logic [RUN_W-1:0] NARROW_CAP = 8'd255;

    localparam logic FUNC_SIZE  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [FMT_W-1:0] FMT_IDS    = 2'd0;
    localparam logic [FMT_W-1:0] FMT_NARROW = 2'd1;
    localparam logic [FMT_W-1:0] FMT_WIDE   = 2'd2;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] glyph_id;
        logic            last_glyph;
    } id_item_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              last_of_item;
        logic              end_of_list;
        logic [FMT_W-1:0]  chosen_format;
        logic [SIZE_W-1:0] encoded_size;
    } res_item_t;

endpackage

### hdl/cff_charset_range_encoder_unit.sv
// CFF charset encoder (formats 0, 1, 2): sizing pass and byte-stream write pass.
// The first result byte of an item is registered and shows in the cycle after the item is taken.
// Throughput: one item per cycle while res_stall is low and each item causes at most
// one byte; an item that causes more bytes holds the input until they drain through the
// single byte-wide result port (format 0 writes give two bytes per id). Items with no result add no hold.
// Reset: rst_n clears the list state, the stored format and the result queue.
module cff_charset_range_encoder_unit
    import cffcs_pkg::*;
#(
    parameter int MAX_IDS = 65535
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      id_valid,
    output logic      id_stall,
    input  id_item_t  id_data,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res_data
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_IDS);

    // list state
    logic [ID_W-1:0]  prev_id_reg, prev_id_next;
    logic             in_list_reg, in_list_next;
    logic [CNT_W-1:0] id_count_reg, id_count_next;
    logic [CNT_W-1:0] narrow_ranges_reg, narrow_ranges_next;
    logic [CNT_W-1:0] wide_ranges_reg, wide_ranges_next;
    logic [RUN_W-1:0] narrow_run_reg, narrow_run_next;
    logic [ID_W-1:0]  wide_run_reg, wide_run_next;
    logic [FMT_W-1:0] fmt_reg, fmt_next;

    // result queue: bytes of the current item, head at index 0
    logic [7:0]        byte_reg [MAX_RESULTS];
    logic [7:0]        byte_next [MAX_RESULTS];
    logic [RCNT_W-1:0] rcnt_reg, rcnt_next;
    logic [FMT_W-1:0]  res_fmt_reg, res_fmt_next;
    logic [SIZE_W-1:0] res_size_reg, res_size_next;
    logic              res_end_reg;

    logic              accept, pop, first, brk, nbrk;
    logic [SIZE_W-1:0] size0, size1, size2;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v < CNT_MAX) ? v + CNT_W'(1) : CNT_MAX;
    endfunction

    // Handshake: take a new item when the queue is empty or its last byte leaves now.
    assign res_valid = (rcnt_reg != '0);
    assign pop       = res_valid && !res_stall;
    assign id_stall  = (rcnt_reg > RCNT_W'(1)) || ((rcnt_reg == RCNT_W'(1)) && res_stall);
    assign accept    = id_valid && !id_stall;

    assign res_data.out_byte      = byte_reg[0];
    assign res_data.last_of_item  = (rcnt_reg == RCNT_W'(1));
    assign res_data.end_of_list   = (rcnt_reg == RCNT_W'(1)) && res_end_reg;
    assign res_data.chosen_format = res_fmt_reg;
    assign res_data.encoded_size  = res_size_reg;

    // Run detection: a run continues only on previous id + 1 without wrap.
    assign first = !in_list_reg;
    assign brk   = ({1'b0, prev_id_reg} + 17'd1) != {1'b0, id_data.glyph_id};
    assign nbrk  = brk || (narrow_run_reg == NARROW_CAP);

    // Candidate sizes from the updated counts.
    assign size0 = SIZE_W'(1) + (SIZE_W'(id_count_next) << 1);
    assign size1 = SIZE_W'(1) + (SIZE_W'(narrow_ranges_next) << 1)
                 + SIZE_W'(narrow_ranges_next);
    assign size2 = SIZE_W'(1) + (SIZE_W'(wide_ranges_next) << 2);

    always_comb
    begin
        prev_id_next       = id_data.glyph_id;
        in_list_next       = !id_data.last_glyph;
        id_count_next      = id_count_reg;
        narrow_ranges_next = narrow_ranges_reg;
        wide_ranges_next   = wide_ranges_reg;
        narrow_run_next    = narrow_run_reg;
        wide_run_next      = wide_run_reg;
        fmt_next           = fmt_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            byte_next[i] = '0;
        end
        rcnt_next     = '0;
        res_fmt_next  = fmt_reg;
        res_size_next = '0;

        if (id_data.func == FUNC_SIZE)
        begin
            if (first)
            begin
                id_count_next      = CNT_W'(1);
                narrow_ranges_next = CNT_W'(1);
                wide_ranges_next   = CNT_W'(1);
                narrow_run_next    = '0;
                wide_run_next      = '0;
            end
            else
            begin
                id_count_next = sat_inc(id_count_reg);
                if (nbrk)
                begin
                    narrow_ranges_next = sat_inc(narrow_ranges_reg);
                    narrow_run_next    = '0;
                end
                else
                begin
                    narrow_run_next = narrow_run_reg + RUN_W'(1);
                end
                if (brk)
                begin
                    wide_ranges_next = sat_inc(wide_ranges_reg);
                    wide_run_next    = '0;
                end
                else
                begin
                    wide_run_next = wide_run_reg + ID_W'(1);
                end
            end
            if (id_data.last_glyph)
            begin
                // tie order: format 0 only if strictly smallest, then 1 if strictly below 2, else 2
                if (size0 < size1)
                begin
                    if (size0 < size2)
                    begin
                        fmt_next      = FMT_IDS;
                        res_size_next = size0;
                    end
                    else
                    begin
                        fmt_next      = FMT_WIDE;
                        res_size_next = size2;
                    end
                end
                else if (size1 < size2)
                begin
                    fmt_next      = FMT_NARROW;
                    res_size_next = size1;
                end
                else
                begin
                    fmt_next      = FMT_WIDE;
                    res_size_next = size2;
                end
                res_fmt_next = fmt_next;
                rcnt_next    = RCNT_W'(1);
            end
        end
        else
        begin
            if (first)
            begin
                narrow_run_next = '0;
                wide_run_next   = '0;
                byte_next[0]    = 8'(fmt_reg);
                byte_next[1]    = id_data.glyph_id[15:8];
                byte_next[2]    = id_data.glyph_id[7:0];
                rcnt_next       = RCNT_W'(3);
            end
            else if (fmt_reg == FMT_NARROW)
            begin
                if (nbrk)
                begin
                    byte_next[0]    = narrow_run_reg;
                    byte_next[1]    = id_data.glyph_id[15:8];
                    byte_next[2]    = id_data.glyph_id[7:0];
                    rcnt_next       = RCNT_W'(3);
                    narrow_run_next = '0;
                end
                else
                begin
                    narrow_run_next = narrow_run_reg + RUN_W'(1);
                end
            end
            else if (fmt_reg == FMT_WIDE)
            begin
                if (brk)
                begin
                    byte_next[0]  = wide_run_reg[15:8];
                    byte_next[1]  = wide_run_reg[7:0];
                    byte_next[2]  = id_data.glyph_id[15:8];
                    byte_next[3]  = id_data.glyph_id[7:0];
                    rcnt_next     = RCNT_W'(4);
                    wide_run_next = '0;
                end
                else
                begin
                    wide_run_next = wide_run_reg + ID_W'(1);
                end
            end
            else
            begin
                byte_next[0] = id_data.glyph_id[15:8];
                byte_next[1] = id_data.glyph_id[7:0];
                rcnt_next    = RCNT_W'(2);
            end
            // close the open range on the final id
            if (id_data.last_glyph)
            begin
                if (fmt_reg == FMT_NARROW)
                begin
                    byte_next[rcnt_next] = narrow_run_next;
                    rcnt_next            = rcnt_next + RCNT_W'(1);
                end
                else if (fmt_reg == FMT_WIDE)
                begin
                    byte_next[rcnt_next]              = wide_run_next[15:8];
                    byte_next[rcnt_next + RCNT_W'(1)] = wide_run_next[7:0];
                    rcnt_next                         = rcnt_next + RCNT_W'(2);
                end
            end
        end
    end

    // Control state: list registers advance on each taken item; the queue count
    // loads on an item and drops by one per delivered byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_id_reg       <= '0;
            in_list_reg       <= 1'b0;
            id_count_reg      <= '0;
            narrow_ranges_reg <= '0;
            wide_ranges_reg   <= '0;
            narrow_run_reg    <= '0;
            wide_run_reg      <= '0;
            fmt_reg           <= FMT_IDS;
            rcnt_reg          <= '0;
        end
        else
        begin
            if (accept)
            begin
                prev_id_reg       <= prev_id_next;
                in_list_reg       <= in_list_next;
                id_count_reg      <= id_count_next;
                narrow_ranges_reg <= narrow_ranges_next;
                wide_ranges_reg   <= wide_ranges_next;
                narrow_run_reg    <= narrow_run_next;
                wide_run_reg      <= wide_run_next;
                fmt_reg           <= fmt_next;
                rcnt_reg          <= rcnt_next;
            end
            else if (pop)
            begin
                rcnt_reg <= rcnt_reg - RCNT_W'(1);
            end
        end
    end

    // Result payload: load on a taken item, shift toward the head on each pop.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                byte_reg[i] <= byte_next[i];
            end
            res_fmt_reg  <= res_fmt_next;
            res_size_reg <= res_size_next;
            res_end_reg  <= id_data.last_glyph;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                byte_reg[i] <= byte_reg[i + 1];
            end
            byte_reg[MAX_RESULTS - 1] <= '0;
        end
    end

endmodule

### tb/cff_charset_checker.sv
// Checker for the CFF charset range encoder: watches both item channels, predicts
// the result bytes of every accepted id item and compares them in order.
// Depends on cffcs_pkg for the item structs, function codes and format codes.
`timescale 1ns / 100ps

module cff_charset_checker
    import cffcs_pkg::*;
#(
    parameter int MAX_IDS = 65535
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      id_valid,
    input  logic      id_stall,
    input  id_item_t  id_data,
    input  logic      res_valid,
    input  logic      res_stall,
    input  res_item_t res_data,
    output int        mismatches,
    output int        outstanding
);

    // Encoder state, kept in step with the block.
    logic [ID_W-1:0]  prev_id    = '0;
    logic             in_list    = 1'b0;
    logic [CNT_W-1:0] id_total   = '0;
    logic [CNT_W-1:0] narrow_cnt = '0;
    logic [CNT_W-1:0] wide_cnt   = '0;
    logic [RUN_W-1:0] narrow_len = '0;
    logic [ID_W-1:0]  wide_len   = '0;
    logic [FMT_W-1:0] kept_fmt   = FMT_IDS;

    res_item_t encoded_stream[$];
    res_item_t oldest;
    int        step_bytes = 0;
    int        byte_index = 0;
    int        fail_total = 0;
    int        queued_len = 0;

    assign mismatches  = fail_total;
    assign outstanding = queued_len;

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
        if (v < CNT_W'(MAX_IDS))
            return v + CNT_W'(1);
        return CNT_W'(MAX_IDS);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH result %0d at %0t: %s", byte_index, $time, what);
        fail_total++;
    endtask

    task automatic check_field(input string field, input logic [SIZE_W-1:0] got,
                               input logic [SIZE_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, want 0x%0h", field, got, want));
    endtask

    task automatic emit(input logic [7:0] b, input logic [FMT_W-1:0] f,
                        input logic [SIZE_W-1:0] sz);
        res_item_t r;
        r.out_byte      = b;
        r.last_of_item  = 1'b0;
        r.end_of_list   = 1'b0;
        r.chosen_format = f;
        r.encoded_size  = sz;
        encoded_stream.push_back(r);
        step_bytes++;
    endtask

    task automatic emit16(input logic [15:0] v, input logic [FMT_W-1:0] f);
        emit(v[15:8], f, '0);
        emit(v[7:0], f, '0);
    endtask

    // Advance the state by one id item and queue the bytes it causes.
    task automatic encode_glyph(input id_item_t it);
        logic             first;
        logic             brk;
        logic             nbrk;
        logic [FMT_W-1:0] fmt;
        logic [FMT_W-1:0] pick;
        int               s0;
        int               s1;
        int               s2;
        int               sz;
        res_item_t        tail;
        first = !in_list;
        // Compare without wrap: an id after 65535 always opens a new range.
        brk   = ({1'b0, prev_id} + 17'd1) != {1'b0, it.glyph_id};
        nbrk  = brk || (narrow_len == NARROW_CAP);
        fmt   = kept_fmt;
        step_bytes = 0;
        if (it.func == FUNC_SIZE)
        begin
            if (first)
            begin
                id_total   = CNT_W'(1);
                narrow_cnt = CNT_W'(1);
                wide_cnt   = CNT_W'(1);
                narrow_len = '0;
                wide_len   = '0;
            end
            else
            begin
                id_total = sat_bump(id_total);
                if (nbrk)
                begin
                    narrow_cnt = sat_bump(narrow_cnt);
                    narrow_len = '0;
                end
                else
                    narrow_len = narrow_len + RUN_W'(1);
                if (brk)
                begin
                    wide_cnt = sat_bump(wide_cnt);
                    wide_len = '0;
                end
                else
                    wide_len = wide_len + ID_W'(1);
            end
            prev_id = it.glyph_id;
            in_list = 1'b1;
            if (it.last_glyph)
            begin
                s0 = 1 + 2 * int'(id_total);
                s1 = 1 + 3 * int'(narrow_cnt);
                s2 = 1 + 4 * int'(wide_cnt);
                if (s0 < s1)
                begin
                    pick = (s0 < s2) ? FMT_IDS : FMT_WIDE;
                    sz   = (s0 < s2) ? s0 : s2;
                end
                else
                begin
                    pick = (s1 < s2) ? FMT_NARROW : FMT_WIDE;
                    sz   = (s1 < s2) ? s1 : s2;
                end
                kept_fmt = pick;
                in_list  = 1'b0;
                emit(8'd0, pick, SIZE_W'(sz));
            end
        end
        else
        begin
            if (first)
            begin
                narrow_len = '0;
                wide_len   = '0;
                emit(8'(fmt), fmt, '0);
                emit16(it.glyph_id, fmt);
            end
            else if (fmt == FMT_NARROW)
            begin
                if (nbrk)
                begin
                    emit(narrow_len, fmt, '0);
                    emit16(it.glyph_id, fmt);
                    narrow_len = '0;
                end
                else
                    narrow_len = narrow_len + RUN_W'(1);
            end
            else if (fmt == FMT_WIDE)
            begin
                if (brk)
                begin
                    emit16(wide_len, fmt);
                    emit16(it.glyph_id, fmt);
                    wide_len = '0;
                end
                else
                    wide_len = wide_len + ID_W'(1);
            end
            else
                emit16(it.glyph_id, fmt);
            prev_id = it.glyph_id;
            in_list = 1'b1;
            if (it.last_glyph)
            begin
                // Close the open range with its count of further ids.
                if (fmt == FMT_NARROW)
                    emit(narrow_len, fmt, '0);
                else if (fmt == FMT_WIDE)
                    emit16(wide_len, fmt);
                in_list = 1'b0;
            end
        end
        if (step_bytes > 0)
        begin
            tail = encoded_stream[encoded_stream.size() - 1];
            tail.last_of_item = 1'b1;
            tail.end_of_list  = it.last_glyph;
            encoded_stream[encoded_stream.size() - 1] = tail;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_id    = '0;
            in_list    = 1'b0;
            id_total   = '0;
            narrow_cnt = '0;
            wide_cnt   = '0;
            narrow_len = '0;
            wide_len   = '0;
            kept_fmt   = FMT_IDS;
            encoded_stream.delete();
            queued_len <= 0;
        end
        else
        begin
            if (id_valid && !id_stall)
                encode_glyph(id_data);
            if (res_valid && !res_stall)
            begin
                if (encoded_stream.size() == 0)
                    report_mismatch($sformatf("unexpected byte 0x%0h", res_data.out_byte));
                else
                begin
                    oldest = encoded_stream.pop_front();
                    check_field("out_byte", SIZE_W'(res_data.out_byte),
                                SIZE_W'(oldest.out_byte));
                    check_field("last_of_item", SIZE_W'(res_data.last_of_item),
                                SIZE_W'(oldest.last_of_item));
                    check_field("end_of_list", SIZE_W'(res_data.end_of_list),
                                SIZE_W'(oldest.end_of_list));
                    check_field("chosen_format", SIZE_W'(res_data.chosen_format),
                                SIZE_W'(oldest.chosen_format));
                    check_field("encoded_size", res_data.encoded_size, oldest.encoded_size);
                end
                byte_index++;
            end
            queued_len <= encoded_stream.size();
        end
    end

endmodule

### tb/tb_cff_charset_range_encoder_unit.sv
// Top of the CFF charset encoder testbench: clock, reset, id stimulus and verdict.
// Depends on cffcs_pkg, cff_charset_range_encoder_unit and cff_charset_checker.
`timescale 1ns / 100ps

module tb_cff_charset_range_encoder_unit;
    import cffcs_pkg::*;

    localparam int MAX_IDS = 65535;

    logic      clk;
    logic      rst_n    = 1'b0;
    logic      id_valid = 1'b0;
    logic      id_stall;
    id_item_t  id_data  = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res_data;

    int mismatches;
    int outstanding;

    // Idle rates in percent; changed per phase of the run.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_items     = 0;
    int phase;
    int mark;

    // Id list under construction; sent once per pass.
    logic [ID_W-1:0] glyph_list[$];

    cff_charset_range_encoder_unit #(.MAX_IDS(MAX_IDS)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .id_valid  (id_valid),
        .id_stall  (id_stall),
        .id_data   (id_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    cff_charset_checker #(.MAX_IDS(MAX_IDS)) u_chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .id_valid    (id_valid),
        .id_stall    (id_stall),
        .id_data     (id_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Stall the result channel at random, one fresh draw per cycle.
    always @(posedge clk)
        res_stall <= ($urandom_range(99) < recv_stall_pct);

    // Offer one id item and hold it until the block takes it. Valid is only
    // lowered here inside an idle gap, so back-to-back items keep it high.
    task automatic send_id(input logic f, input logic [ID_W-1:0] gid, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            id_valid <= 1'b0;
            @(posedge clk);
        end
        id_valid <= 1'b1;
        id_data  <= '{func: f, glyph_id: gid, last_glyph: lst};
        @(posedge clk);
        while (id_stall)
            @(posedge clk);
        sent_items++;
    endtask

    // Drop valid and hold off until every predicted byte has come out.
    task automatic drain_results();
        id_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Stream the current list in one pass, marking its final id.
    task automatic send_list(input logic f);
        foreach (glyph_list[i])
            send_id(f, glyph_list[i], i == glyph_list.size() - 1);
    endtask

    // Build a short list out of runs. The style steers the winning format:
    // isolated ids favor format 0, short runs favor format 1.
    task automatic random_list();
        int              style;
        int              len;
        int              run_len;
        logic [ID_W-1:0] g;
        style = $urandom_range(2);
        len   = $urandom_range(16, 1);
        g     = 16'($urandom);
        glyph_list.delete();
        while (glyph_list.size() < len)
        begin
            case (style)
                0:       run_len = ($urandom_range(9) == 0) ? 2 : 1;
                1:       run_len = $urandom_range(4, 1);
                default: run_len = $urandom_range(12, 2);
            endcase
            for (int k = 0; k < run_len && glyph_list.size() < len; k++)
            begin
                glyph_list.push_back(g);
                g++;
            end
            // Jump to a new start; now and then just below the wrap, or repeat an id.
            case ($urandom_range(15))
                0, 1:    g = 16'hFFFF - 16'($urandom_range(2));
                2:       g = glyph_list[glyph_list.size() - 1];
                default: g = 16'($urandom);
            endcase
        end
    endtask

    // Free-form items: random pass per id, random list ends, lists left open.
    task automatic noise_items();
        int cnt;
        cnt = $urandom_range(10, 1);
        repeat (cnt)
            send_id(1'($urandom_range(1)), 16'($urandom), $urandom_range(3) == 0);
    endtask

    // Sizing pass over one run past the 255 cap of format 1 plus three isolated
    // ids: the cap splits the run in two, so format 1 wins at 16 bytes.
    task automatic long_run_list();
        logic [ID_W-1:0] g;
        int              run_len;
        g       = 16'($urandom_range(64000));
        run_len = $urandom_range(270, 257);
        glyph_list.delete();
        repeat (run_len)
        begin
            glyph_list.push_back(g);
            g++;
        end
        repeat (3)
        begin
            g = g + 16'd2 + 16'($urandom_range(100));
            glyph_list.push_back(g);
        end
        send_list(FUNC_SIZE);
    endtask

    // Mostly sized-then-written lists; the rest are broken sequences.
    task automatic random_round();
        case ($urandom_range(19))
            0, 1:
                noise_items();
            2:
            begin
                // Write with whatever format the last sizing left behind.
                random_list();
                send_list(FUNC_WRITE);
            end
            3:
            begin
                random_list();
                send_list(FUNC_SIZE);
            end
            default:
            begin
                random_list();
                send_list(FUNC_SIZE);
                send_list(FUNC_WRITE);
            end
        endcase
        if ($urandom_range(7) == 0)
            drain_results();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 33;
        recv_stall_pct = 62;

        // Write pass straight out of reset: the stored format is still 0.
        // The second id follows 65535, so it opens a new range.
        send_id(FUNC_WRITE, 16'hFFFF, 1'b0);
        send_id(FUNC_WRITE, 16'h0000, 1'b1);
        drain_results();

        // A run crossing the wrap splits in two; format 1 wins.
        glyph_list = '{16'hFFFE, 16'hFFFF, 16'h0000, 16'h0001};
        send_list(FUNC_SIZE);
        send_list(FUNC_WRITE);

        // Ids and narrow ranges tie at size 7: format 1 takes the tie.
        glyph_list = '{16'd1, 16'd2, 16'd7};
        send_list(FUNC_SIZE);
        send_list(FUNC_WRITE);

        // Single id list: format 0.
        glyph_list = '{16'h8000};
        send_list(FUNC_SIZE);
        send_list(FUNC_WRITE);

        // Switch passes in the middle of a list; state is shared.
        send_id(FUNC_SIZE, 16'h1234, 1'b0);
        send_id(FUNC_WRITE, 16'h1235, 1'b0);
        send_id(FUNC_SIZE, 16'h00FF, 1'b1);

        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 62;
                end
                1:
                begin
                    send_idle_pct  = 62;
                    recv_stall_pct = 33;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            mark = sent_items;
            while (sent_items < mark + 50)
                random_round();
        end

        // Deep case at full rate: the narrow cap in the sizing pass, then a
        // short list written in the format it left behind.
        long_run_list();
        random_list();
        send_list(FUNC_WRITE);

        // Let the last bytes out, then keep the clock running so the block can
        // show anything it should not.
        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Bound the run well past the slowest correct one.
    initial
    begin
        #8ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
